FILE: hw/rtl/aabb_cs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AABB collision search package
// Transfer types, operation codes, register indexes and widths shared by the
// collision search block.
// ----------------------------------------------------------------------------
package aabb_cs_pkg;

    localparam int ENTRIES_DEF = 64;
    localparam int COORD_W     = 24;
    localparam int MARGIN_W    = 16;
    localparam int TAG_W       = 8;
    localparam int DEPTH_W     = 24;
    localparam int INDEX_W     = 6;
    // Grown query coordinates and overlap differences.
    localparam int GROW_W      = 25;
    localparam int DIFF_W      = 26;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP   = 1'b1;

    typedef struct packed {
        logic [1:0]                op;
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_z;
        logic [TAG_W-1:0]          tag;
    } t_in;

    typedef struct packed {
        logic                status;
        logic                hit;
        logic [INDEX_W-1:0]  match_index;
        logic [TAG_W-1:0]    match_tag;
        logic [DEPTH_W-1:0]  depth;
    } t_out;

    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_z;
        logic [TAG_W-1:0]          tag;
    } t_entry;

endpackage

FILE: hw/rtl/aabb_collision_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AABB collision search
// Keeps a table of obstacle boxes in a RAM and answers clear, append and
// query transfers with one result each.
//
//   Channel   Signals                           Direction
//   input     i_valid, o_stall, i_data (t_in)    into the block
//   output    o_valid, i_stall, o_data (t_out)   out of the block
//   config    i_cfg_we, i_cfg_idx, i_cfg_data    into the block
//
// A query scans the stored boxes one per cycle through the single RAM read
// port and ends at the first hit or after the last stored box.
// Reset is synchronous and active low; it empties the table.
// One transfer is worked on at a time; a new one is taken while the previous
// result waits in the output register, and a stalled result holds the block.
// ----------------------------------------------------------------------------
module aabb_collision_search
    import aabb_cs_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_in                  i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_out                 o_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [MARGIN_W-1:0]  i_cfg_data
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int EW = $bits(t_entry);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_issue;
    logic [MARGIN_W-1:0] r_margin;
    logic                r_skip;
    logic                r_out_valid;
    t_out                r_out;
    t_out                r_res;

    logic signed [GROW_W-1:0] r_qmin [3];
    logic signed [GROW_W-1:0] r_qmax [3];
    logic [TAG_W-1:0]         r_qtag;

    logic                     r_rd_v;
    logic [AW-1:0]            r_rd_idx;
    logic                     r_p_v;
    logic                     r_p_hit;
    logic [AW-1:0]            r_p_idx;
    logic [TAG_W-1:0]         r_p_tag;
    logic signed [GROW_W-1:0] r_p_hi [3];
    logic signed [GROW_W-1:0] r_p_lo [3];
    logic                     r_q_v;
    logic                     r_q_hit;
    logic [AW-1:0]            r_q_idx;
    logic [TAG_W-1:0]         r_q_tag;
    logic [DEPTH_W-1:0]       r_q_ov [3];

    logic                     w_accept;
    logic                     w_full;
    logic                     w_we;
    t_entry                   w_wentry;
    logic [EW-1:0]            w_rdata;
    t_entry                   w_ent;
    logic                     w_more;
    logic                     w_issue;
    logic                     w_hit_done;
    logic                     w_miss_done;
    logic                     w_finish;
    logic signed [GROW_W-1:0] w_smin [3];
    logic signed [GROW_W-1:0] w_smax [3];
    logic signed [GROW_W-1:0] w_imin [3];
    logic signed [GROW_W-1:0] w_imax [3];
    logic [2:0]               w_axis_ok;
    logic                     w_cand;
    logic signed [DIFF_W-1:0] w_diff [3];
    logic [DEPTH_W-1:0]       w_ovc [3];
    logic [DEPTH_W-1:0]       w_m01;
    logic [DEPTH_W-1:0]       w_dmin;
    logic [31:0]              w_idx_ext;

    assign w_accept = i_valid && !o_stall;
    assign w_full   = (r_count >= CW'(ENTRIES));
    assign w_we     = w_accept && (i_data.op == OP_APPEND) && !w_full;

    assign w_wentry.min_x = i_data.min_x;
    assign w_wentry.min_y = i_data.min_y;
    assign w_wentry.min_z = i_data.min_z;
    assign w_wentry.max_x = i_data.max_x;
    assign w_wentry.max_y = i_data.max_y;
    assign w_wentry.max_z = i_data.max_z;
    assign w_wentry.tag   = i_data.tag;

    assign w_more      = (r_issue < r_count);
    assign w_hit_done  = (r_state == S_SCAN) && r_q_v && r_q_hit;
    assign w_miss_done = (r_state == S_SCAN) && !w_more && !r_rd_v && !r_p_v && !r_q_v;
    assign w_finish    = w_hit_done || w_miss_done;
    assign w_issue     = (r_state == S_SCAN) && !w_finish && w_more;

    aabb_cs_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_wentry),
        .i_re    (w_issue),
        .i_raddr (r_issue[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_ent = t_entry'(w_rdata);

    assign w_smin[0] = GROW_W'(w_ent.min_x);
    assign w_smin[1] = GROW_W'(w_ent.min_y);
    assign w_smin[2] = GROW_W'(w_ent.min_z);
    assign w_smax[0] = GROW_W'(w_ent.max_x);
    assign w_smax[1] = GROW_W'(w_ent.max_y);
    assign w_smax[2] = GROW_W'(w_ent.max_z);
    assign w_imin[0] = GROW_W'(i_data.min_x);
    assign w_imin[1] = GROW_W'(i_data.min_y);
    assign w_imin[2] = GROW_W'(i_data.min_z);
    assign w_imax[0] = GROW_W'(i_data.max_x);
    assign w_imax[1] = GROW_W'(i_data.max_y);
    assign w_imax[2] = GROW_W'(i_data.max_z);

    // Per-axis interval test; touching faces count as overlap.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_axis_ok[a] = !(r_qmin[a] > w_smax[a]) && !(w_smin[a] > r_qmax[a]);
        end
    end

    assign w_cand = (&w_axis_ok) && !(r_skip && (w_ent.tag == r_qtag));

    // Overlap per axis, clamped to the depth range.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_diff[a] = DIFF_W'(r_p_hi[a]) - DIFF_W'(r_p_lo[a]);
            if (w_diff[a][DIFF_W-1]) begin
                w_ovc[a] = '0;
            end else if (|w_diff[a][DIFF_W-2:DEPTH_W]) begin
                w_ovc[a] = DEPTH_MAX;
            end else begin
                w_ovc[a] = w_diff[a][DEPTH_W-1:0];
            end
        end
    end

    assign w_m01     = (r_q_ov[1] < r_q_ov[0]) ? r_q_ov[1] : r_q_ov[0];
    assign w_dmin    = (r_q_ov[2] < w_m01) ? r_q_ov[2] : w_m01;
    assign w_idx_ext = 32'(r_q_idx);

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_p_hi[a] <= (r_qmax[a] < w_smax[a]) ? r_qmax[a] : w_smax[a];
            r_p_lo[a] <= (r_qmin[a] > w_smin[a]) ? r_qmin[a] : w_smin[a];
            r_q_ov[a] <= w_ovc[a];
        end
        r_rd_idx <= r_issue[AW-1:0];
        r_p_hit  <= w_cand;
        r_p_idx  <= r_rd_idx;
        r_p_tag  <= w_ent.tag;
        r_q_hit  <= r_p_hit;
        r_q_idx  <= r_p_idx;
        r_q_tag  <= r_p_tag;
        if (w_accept && (i_data.op == OP_QUERY)) begin
            for (int a = 0; a < 3; a++) begin
                r_qmin[a] <= w_imin[a] - $signed(GROW_W'(r_margin));
                r_qmax[a] <= w_imax[a] + $signed(GROW_W'(r_margin));
            end
            r_qtag <= i_data.tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_issue     <= '0;
            r_margin    <= '0;
            r_skip      <= 1'b1;
            r_out_valid <= 1'b0;
            r_out       <= '0;
            r_res       <= '0;
            r_rd_v      <= 1'b0;
            r_p_v       <= 1'b0;
            r_q_v       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MARGIN: r_margin <= i_cfg_data;
                    REG_SKIP:   r_skip   <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            r_rd_v <= w_issue;
            r_p_v  <= r_rd_v && !w_finish;
            r_q_v  <= r_p_v && !w_finish;

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_res <= '0;
                        case (i_data.op)
                            OP_CLEAR: begin
                                r_count <= '0;
                                r_state <= S_DONE;
                            end
                            OP_APPEND: begin
                                if (w_full) begin
                                    r_res.status <= 1'b1;
                                end else begin
                                    r_count <= r_count + 1'b1;
                                end
                                r_state <= S_DONE;
                            end
                            OP_QUERY: begin
                                r_issue <= '0;
                                r_state <= S_SCAN;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (w_issue) begin
                        r_issue <= r_issue + 1'b1;
                    end
                    if (w_hit_done) begin
                        r_res.hit         <= 1'b1;
                        r_res.match_index <= w_idx_ext[INDEX_W-1:0];
                        r_res.match_tag   <= r_q_tag;
                        r_res.depth       <= w_dmin;
                        r_state           <= S_DONE;
                    end else if (w_miss_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ENTRIES))
        else $error("entry count beyond table size");

    a_scan_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_SCAN) |-> (!r_rd_v && !r_p_v && !r_q_v))
        else $error("scan pipeline busy outside a query");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.hit) |->
            (o_data.depth == '0 && o_data.match_index == '0 && o_data.match_tag == '0))
        else $error("result without hit carries match fields");

    a_status_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_data.status && o_data.hit))
        else $error("result flags both a dropped append and a hit");

endmodule

FILE: hw/rtl/aabb_cs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with the read data registered.
// ----------------------------------------------------------------------------
module aabb_cs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: bench/aabb_collision_search_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AABB collision search testbench
// Drives clear, append and query transfers into the collision search block
// with random bursts and gaps while the result side stalls on its own pattern.
// A behavioral copy of the obstacle table predicts every result, and each
// result is compared field by field with the oldest prediction. Directed
// cases cover empty and full tables, touching and inverted boxes, tag skipping,
// margin growth at the coordinate extremes and the unused operation code,
// followed by random table builds and queries under several register settings.
// ----------------------------------------------------------------------------
module aabb_collision_search_tb;
    import aabb_cs_pkg::*;

    localparam int TABLE_DEPTH = ENTRIES_DEF;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int MAX_PRINTED = 40;
    localparam int COORD_LOW = -8388608;
    localparam int COORD_HIGH = 8388607;
    localparam int PHASE_ITEMS = 110;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    t_in                  i_data = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    t_out                 o_data;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = REG_MARGIN;
    logic [MARGIN_W-1:0]  i_cfg_data = '0;

    t_entry box_table [TABLE_DEPTH];
    int     box_count = 0;
    longint grow_margin = 0;
    bit     skip_own_tag = 1'b1;
    t_out   pending_results [$];
    t_out   oldest_result;

    int error_count = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_left = 0;

    aabb_collision_search uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("aabb_collision_search_tb: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 3) != 0);
            default: i_stall <= ((cycle_count % 7) < 3);
        endcase
    end

    function automatic t_out collision_result(input t_in item);
        t_out   r;
        longint qlo [3];
        longint qhi [3];
        longint slo [3];
        longint shi [3];
        longint ov;
        longint dep;
        bit     overlap;
        r = '0;
        case (item.op)
            OP_CLEAR: begin
                box_count = 0;
            end
            OP_APPEND: begin
                if (box_count >= TABLE_DEPTH) begin
                    r.status = 1'b1;
                end else begin
                    box_table[box_count].min_x = item.min_x;
                    box_table[box_count].min_y = item.min_y;
                    box_table[box_count].min_z = item.min_z;
                    box_table[box_count].max_x = item.max_x;
                    box_table[box_count].max_y = item.max_y;
                    box_table[box_count].max_z = item.max_z;
                    box_table[box_count].tag   = item.tag;
                    box_count++;
                end
            end
            OP_QUERY: begin
                qlo[0] = $signed(item.min_x) - grow_margin;
                qlo[1] = $signed(item.min_y) - grow_margin;
                qlo[2] = $signed(item.min_z) - grow_margin;
                qhi[0] = $signed(item.max_x) + grow_margin;
                qhi[1] = $signed(item.max_y) + grow_margin;
                qhi[2] = $signed(item.max_z) + grow_margin;
                for (int i = 0; i < box_count; i++) begin
                    if (!r.hit && !(skip_own_tag && box_table[i].tag == item.tag)) begin
                        slo[0] = $signed(box_table[i].min_x);
                        slo[1] = $signed(box_table[i].min_y);
                        slo[2] = $signed(box_table[i].min_z);
                        shi[0] = $signed(box_table[i].max_x);
                        shi[1] = $signed(box_table[i].max_y);
                        shi[2] = $signed(box_table[i].max_z);
                        overlap = 1'b1;
                        dep = 0;
                        for (int a = 0; a < 3; a++) begin
                            if (qlo[a] > shi[a] || slo[a] > qhi[a]) begin
                                overlap = 1'b0;
                            end
                            ov = ((qhi[a] < shi[a]) ? qhi[a] : shi[a])
                                 - ((qlo[a] > slo[a]) ? qlo[a] : slo[a]);
                            if (a == 0 || ov < dep) begin
                                dep = ov;
                            end
                        end
                        if (overlap) begin
                            if (dep < 0) begin
                                dep = 0;
                            end
                            if (dep > longint'(DEPTH_MAX)) begin
                                dep = longint'(DEPTH_MAX);
                            end
                            r.hit = 1'b1;
                            r.match_index = i[INDEX_W-1:0];
                            r.match_tag = box_table[i].tag;
                            r.depth = dep[DEPTH_W-1:0];
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", longint'(o_data.depth), 0);
            end else begin
                oldest_result = pending_results.pop_front();
                if (o_data.status !== oldest_result.status) begin
                    report_mismatch("status", o_data.status, oldest_result.status);
                end
                if (o_data.hit !== oldest_result.hit) begin
                    report_mismatch("hit", o_data.hit, oldest_result.hit);
                end
                if (o_data.match_index !== oldest_result.match_index) begin
                    report_mismatch("match_index", o_data.match_index,
                                    oldest_result.match_index);
                end
                if (o_data.match_tag !== oldest_result.match_tag) begin
                    report_mismatch("match_tag", o_data.match_tag, oldest_result.match_tag);
                end
                if (o_data.depth !== oldest_result.depth) begin
                    report_mismatch("depth", o_data.depth, oldest_result.depth);
                end
            end
        end
    end

    task automatic send_item(input t_in item);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            case ($urandom_range(0, 5))
                0, 1: gap = 0;
                2: gap = $urandom_range(10, 40);
                default: gap = $urandom_range(1, 6);
            endcase
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_data  <= item;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(collision_result(item));
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MARGIN_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_MARGIN: grow_margin = value;
            REG_SKIP: skip_own_tag = value[0];
            default: ;
        endcase
    endtask

    function automatic t_in make_box(input logic [1:0] op, input int lo_x, input int lo_y,
                                     input int lo_z, input int hi_x, input int hi_y,
                                     input int hi_z, input int tag);
        t_in b;
        b.op = op;
        b.min_x = lo_x[COORD_W-1:0];
        b.min_y = lo_y[COORD_W-1:0];
        b.min_z = lo_z[COORD_W-1:0];
        b.max_x = hi_x[COORD_W-1:0];
        b.max_y = hi_y[COORD_W-1:0];
        b.max_z = hi_z[COORD_W-1:0];
        b.tag = tag[TAG_W-1:0];
        return b;
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return COORD_W'($urandom);
            1: return ($urandom_range(0, 1) != 0) ? COORD_W'(COORD_LOW) : COORD_W'(COORD_HIGH);
            default: return COORD_W'($urandom_range(0, 8191) - 4096);
        endcase
    endfunction

    function automatic int rand_span();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return -int'($urandom_range(1, 512));
            2: return $urandom;
            default: return $urandom_range(1, 2048);
        endcase
    endfunction

    function automatic logic [TAG_W-1:0] rand_tag();
        return ($urandom_range(0, 4) == 0) ? TAG_W'($urandom) : TAG_W'($urandom_range(0, 3));
    endfunction

    function automatic t_in rand_box(input logic [1:0] op, input logic [TAG_W-1:0] tag);
        t_in               b;
        logic [COORD_W-1:0] lo [3];
        logic [COORD_W-1:0] hi [3];
        for (int a = 0; a < 3; a++) begin
            lo[a] = rand_coord();
            hi[a] = lo[a] + COORD_W'(rand_span());
        end
        b.op = op;
        b.tag = tag;
        b.min_x = lo[0];
        b.min_y = lo[1];
        b.min_z = lo[2];
        b.max_x = hi[0];
        b.max_y = hi[1];
        b.max_z = hi[2];
        return b;
    endfunction

    function automatic t_in query_item(input logic [TAG_W-1:0] tag);
        t_in    q;
        t_entry e;
        if (box_count == 0 || $urandom_range(0, 3) == 0) begin
            return rand_box(OP_QUERY, tag);
        end
        e = box_table[$urandom_range(0, box_count - 1)];
        q.op = OP_QUERY;
        q.tag = tag;
        q.min_x = e.min_x + COORD_W'($urandom_range(0, 1200) - 600);
        q.min_y = e.min_y + COORD_W'($urandom_range(0, 1200) - 600);
        q.min_z = e.min_z + COORD_W'($urandom_range(0, 1200) - 600);
        q.max_x = e.max_x + COORD_W'($urandom_range(0, 1200) - 600);
        q.max_y = e.max_y + COORD_W'($urandom_range(0, 1200) - 600);
        q.max_z = e.max_z + COORD_W'($urandom_range(0, 1200) - 600);
        return q;
    endfunction

    function automatic t_in noise_item();
        logic [159:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
        return bits[$bits(t_in)-1:0];
    endfunction

    task automatic test_directed_cases();
        send_item(make_box(OP_QUERY, -10, -10, -10, 10, 10, 10, 0));
        send_item(make_box(OP_APPEND, COORD_LOW, COORD_LOW, COORD_LOW,
                           COORD_HIGH, COORD_HIGH, COORD_HIGH, 255));
        send_item(make_box(OP_APPEND, 100, 100, 100, -100, -100, -100, 2));
        send_item(make_box(OP_APPEND, 0, 0, 0, 256, 256, 256, 1));
        send_item(make_box(OP_QUERY, COORD_LOW, COORD_LOW, COORD_LOW,
                           COORD_HIGH, COORD_HIGH, COORD_HIGH, 0));
        send_item(make_box(OP_QUERY, -200, -200, -200, 200, 200, 200, 255));
        send_item(make_box(OP_QUERY, -50, -50, -50, 50, 50, 50, 255));
        send_item(make_box(OP_QUERY, -300, 10, 10, 0, 20, 20, 255));
        send_item(make_box(OP_QUERY, -300, 10, 10, -1, 20, 20, 255));
        send_item(make_box(OP_QUERY, -1, -1, -1, -1, -1, -1, 1));
        send_item(make_box(OP_UNUSED, -1, -1, -1, -1, -1, -1, 255));
        send_item(make_box(OP_QUERY, 0, 0, 0, 0, 0, 0, 255));
        send_item(make_box(OP_CLEAR, -1, -1, -1, -1, -1, -1, 255));
        send_item(make_box(OP_QUERY, COORD_LOW, COORD_LOW, COORD_LOW,
                           COORD_HIGH, COORD_HIGH, COORD_HIGH, 0));
    endtask

    task automatic test_register_extremes();
        wait_idle();
        write_reg(REG_MARGIN, '1);
        write_reg(REG_SKIP, MARGIN_W'(0));
        send_item(make_box(OP_APPEND, 8388000, 8388000, 8388000,
                           COORD_HIGH, COORD_HIGH, COORD_HIGH, 5));
        send_item(make_box(OP_APPEND, COORD_LOW, COORD_LOW, COORD_LOW,
                           COORD_HIGH, COORD_HIGH, COORD_HIGH, 5));
        send_item(make_box(OP_QUERY, COORD_LOW, COORD_LOW, COORD_LOW,
                           COORD_LOW, COORD_LOW, COORD_LOW, 5));
        send_item(make_box(OP_QUERY, COORD_HIGH, COORD_HIGH, COORD_HIGH,
                           COORD_HIGH, COORD_HIGH, COORD_HIGH, 5));
        send_item(make_box(OP_QUERY, 0, 0, 0, 0, 0, 0, 5));
        send_item(make_box(OP_QUERY, COORD_HIGH, COORD_HIGH, COORD_HIGH,
                           COORD_LOW, COORD_LOW, COORD_LOW, 7));
        wait_idle();
        write_reg(REG_MARGIN, MARGIN_W'(0));
        write_reg(REG_SKIP, MARGIN_W'(1));
        send_item(make_box(OP_QUERY, 0, 0, 0, 0, 0, 0, 5));
        send_item(make_box(OP_QUERY, 8387000, 8387000, 8387000,
                           8387700, 8387700, 8387700, 6));
        wait_idle();
        write_reg(REG_MARGIN, MARGIN_W'(300));
        send_item(make_box(OP_QUERY, 8387000, 8387000, 8387000,
                           8387700, 8387700, 8387700, 6));
        send_item(make_box(OP_QUERY, 8387000, 8387000, 8387000,
                           8387699, 8387699, 8387699, 6));
    endtask

    task automatic test_table_full();
        wait_idle();
        write_reg(REG_MARGIN, MARGIN_W'(16));
        write_reg(REG_SKIP, MARGIN_W'(1));
        send_item(make_box(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        repeat (TABLE_DEPTH) send_item(rand_box(OP_APPEND, rand_tag()));
        repeat (3) send_item(rand_box(OP_APPEND, rand_tag()));
        repeat (12) send_item(query_item(rand_tag()));
        send_item(make_box(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        send_item(rand_box(OP_QUERY, rand_tag()));
    endtask

    task automatic test_random_traffic();
        int phase_items;
        int boxes;
        t_in noise;
        for (int phase = 0; phase < 8; phase++) begin
            wait_idle();
            case (phase % 4)
                0: write_reg(REG_MARGIN, MARGIN_W'(0));
                1: write_reg(REG_MARGIN, '1);
                2: write_reg(REG_MARGIN, MARGIN_W'($urandom_range(0, 255)));
                default: write_reg(REG_MARGIN, MARGIN_W'($urandom));
            endcase
            write_reg(REG_SKIP, MARGIN_W'((phase + 1) % 2));
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                if ($urandom_range(0, 6) == 0) begin
                    repeat ($urandom_range(1, 6)) begin
                        noise = noise_item();
                        send_item(noise);
                        if (noise.op != OP_UNUSED) begin
                            phase_items++;
                        end
                    end
                end else begin
                    boxes = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 70)
                                                        : $urandom_range(1, 10);
                    send_item(rand_box(OP_CLEAR, rand_tag()));
                    repeat (boxes) send_item(rand_box(OP_APPEND, rand_tag()));
                    phase_items += boxes + 1;
                    repeat ($urandom_range(2, 12)) begin
                        send_item(query_item(rand_tag()));
                        phase_items++;
                    end
                end
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_register_extremes();
        test_table_full();
        test_random_traffic();
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("aabb_collision_search_tb: clean");
        end else begin
            $display("aabb_collision_search_tb: errors");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/aabb_cs_pkg.sv
hw/rtl/aabb_cs_ram.sv
hw/rtl/aabb_collision_search.sv
bench/aabb_collision_search_tb.sv
